@@ sv/aes128_block_cipher_assert.svh @@
// Assertion macros for the AES-128 engine
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH

// implication checked every edge outside reset
`define AES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aes assertion failed");

// next-cycle implication
`define AES_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aes assertion failed");

`endif

@@ sv/aes_pkg.sv @@
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RkDepth   = 2 * (NumRounds + 1);
  localparam int unsigned RkAw      = 5;

  localparam logic [7:0] Poly     = 8'h1b;
  localparam logic [7:0] AffConst = 8'h63;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StExp   = 5'b00010,
    StLoad  = 5'b00100,
    StRound = 5'b01000,
    StOut   = 5'b10000
  } aes_state_e;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? Poly : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, b);
      b = gf_mul(b, b);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_f(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    sbox_f = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ AffConst;
  endfunction

  function automatic logic [7:0] isbox_f(input logic [7:0] x);
    isbox_f = gf_inv(rotl(x, 1) ^ rotl(x, 3) ^ rotl(x, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t mk_sbox(input logic inv);
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? isbox_f(8'(i)) : sbox_f(8'(i));
    end
    mk_sbox = t;
  endfunction

  localparam sbox_t Sbox  = mk_sbox(1'b0);
  localparam sbox_t ISbox = mk_sbox(1'b1);

endpackage

@@ sv/aes_ram.sv @@
module aes_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 22,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule

@@ sv/aes_round.sv @@
// One shared round unit: forward or inverse round on a 128-bit state.
module aes_round import aes_pkg::*; (
  input  logic [127:0] state_i,
  input  logic         inv_i,
  input  logic         mix_i,
  input  logic [127:0] rkey_i,
  output logic [127:0] state_o
);
  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] u [16];
  logic [7:0] m [16];

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = state_i[127-8*i -: 8];
    // fwd: sub then shift; inv: inverse shift then inverse sub (commute)
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv_i) t[r + 4*((c + r) % 4)] = ISbox[s[r + 4*c]];
        else       t[r + 4*c] = Sbox[s[r + 4*((c + r) % 4)]];
      end
    end
    // inverse round adds key before inverse mix
    for (int i = 0; i < 16; i++) u[i] = inv_i ? (t[i] ^ rkey_i[127-8*i -: 8]) : t[i];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv_i)
          m[4*c+r] = gf_mul(8'h0e, u[4*c+r]) ^ gf_mul(8'h0b, u[4*c+(r+1)%4])
                   ^ gf_mul(8'h0d, u[4*c+(r+2)%4]) ^ gf_mul(8'h09, u[4*c+(r+3)%4]);
        else
          m[4*c+r] = xtime(u[4*c+r]) ^ xtime(u[4*c+(r+1)%4]) ^ u[4*c+(r+1)%4]
                   ^ u[4*c+(r+2)%4] ^ u[4*c+(r+3)%4];
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (inv_i) state_o[127-8*i -: 8] = mix_i ? m[i] : u[i];
      else       state_o[127-8*i -: 8] = (mix_i ? m[i] : u[i]) ^ rkey_i[127-8*i -: 8];
    end
  end
endmodule

@@ sv/aes128_block_cipher.sv @@
// AES-128 single-block engine.
// Config: wr_en_i/wr_idx_i/wr_data_i write key_high (0) or key_low (1).
//   Any key write marks the round keys stale, except one during the last StExp cycle.
// Input channel: in_valid_i/in_stall_o carry action_i (0 enc, 1 dec) and the
//   block; a transfer happens when valid is high and stall low.
// Output channel: out_valid_o/out_stall_i carry the result.
// With round keys current, an accepted block goes through the load step (initial
//   key addition), then 10 rounds, then the out register. Each round key is two
//   64-bit words from the one-read-port RAM, read through its registered output,
//   so the shared round unit's result is taken once both words are on hand.
// No new block is taken until the result has transferred and the engine is back
//   in idle; a stalling receiver keeps it busy longer.
// Key expansion after a key change produces all 44 words (one word per cycle)
//   ahead of the first block, run when that block is taken.
// The block is busy (stall high) from a transfer until its result transfers.
// Reset clears the control state and marks the keys stale; a stalled result
//   is held steady until the receiver takes it.
module aes128_block_cipher import aes_pkg::*; #(
  parameter int unsigned Rounds = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic        wr_idx_i,
  input  logic [63:0] wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);
  `include "aes128_block_cipher_assert.svh"

  localparam int unsigned ExpWords = 4 * (Rounds + 1);
  localparam int unsigned Aw = $clog2(2 * (Rounds + 1));
  localparam int unsigned Ew = $clog2(ExpWords + 1);
  localparam int unsigned Rw = $clog2(Rounds + 1);

  aes_state_e state_q, state_d;
  logic [63:0]  key_hi_q, key_lo_q;
  logic         keys_ok_q;
  logic         dec_q;
  logic [127:0] blk_q;
  logic [127:0] res_q;
  logic [Rw-1:0] rnd_q;     // round index being applied
  logic          half_q;    // 0: high word on read data, 1: low word
  logic [63:0]   rk_hi_q;
  // key expansion: sliding window of last four words
  logic [31:0]   w_q [4];
  logic [Ew-1:0] ecnt_q;
  logic [7:0]    rc_q;
  logic [31:0]   hold_q;

  // round key RAM
  logic          ram_we;
  logic [Aw-1:0] ram_wa, ram_ra;
  logic [63:0]   ram_wd, ram_rd;

  aes_ram #(.Width(64), .Depth(2 * (Rounds + 1)), .Aw(Aw)) u_rk (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // next expanded word
  logic [31:0] t_w, new_w;
  always_comb begin
    t_w = w_q[3];
    if (ecnt_q[1:0] == 2'd0) begin
      t_w = {Sbox[w_q[3][23:16]] ^ rc_q, Sbox[w_q[3][15:8]],
             Sbox[w_q[3][7:0]], Sbox[w_q[3][31:24]]};
    end
    new_w = w_q[0] ^ t_w;
  end

  // write each odd word paired with previous; words 0..3 come from key
  logic [31:0] cur_w;
  assign cur_w = (ecnt_q < Ew'(4)) ? w_q[ecnt_q[1:0]] : new_w;
  assign ram_we = (state_q == StExp) && ecnt_q[0];
  assign ram_wa = Aw'(ecnt_q >> 1);
  assign ram_wd = {hold_q, cur_w};

  logic in_acc, out_acc;

  // read address is formed from the next-state index, as the RAM output is registered
  logic [Rw-1:0] rnd_n;
  logic          half_n;
  logic          dec_n;
  always_comb begin
    dec_n  = in_acc ? action_i : dec_q;
    half_n = 1'b0;
    rnd_n  = rnd_q;
    case (state_q)
      StIdle:  rnd_n = '0;
      StLoad: begin
        half_n = ~half_q;
        if (half_q) rnd_n = Rw'(1);
      end
      StRound: begin
        half_n = ~half_q;
        if (half_q) rnd_n = rnd_q + Rw'(1);
      end
      default: ;
    endcase
  end

  logic [Rw-1:0] rk_idx;
  assign rk_idx = dec_n ? Rw'(Rounds - rnd_n) : rnd_n;
  assign ram_ra = Aw'({rk_idx, half_n});

  logic [127:0] rnd_out;
  logic         mix;
  assign mix = (rnd_q != Rw'(Rounds));
  aes_round u_round (
    .state_i(blk_q), .inv_i(dec_q), .mix_i(mix),
    .rkey_i({rk_hi_q, ram_rd}), .state_o(rnd_out)
  );

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign result_high_o = res_q[127:64];
  assign result_low_o  = res_q[63:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc) state_d = keys_ok_q ? StLoad : StExp;
      StExp:   if (ecnt_q == Ew'(ExpWords - 1)) state_d = StLoad;
      StLoad:  if (half_q) state_d = StRound;
      StRound: if (half_q && rnd_q == Rw'(Rounds)) state_d = StOut;
      StOut:   if (out_acc) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      keys_ok_q <= 1'b0;
      key_hi_q  <= '0;
      key_lo_q  <= '0;
      ecnt_q    <= '0;
      rnd_q     <= '0;
      half_q    <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en_i && wr_idx_i == RegKeyHigh) begin
        key_hi_q <= wr_data_i; keys_ok_q <= 1'b0;
      end
      if (wr_en_i && wr_idx_i == RegKeyLow) begin
        key_lo_q <= wr_data_i; keys_ok_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          ecnt_q <= '0;
          rnd_q  <= '0;
          half_q <= 1'b0;
        end
        StExp: begin
          ecnt_q <= ecnt_q + Ew'(1);
          if (ecnt_q == Ew'(ExpWords - 1)) keys_ok_q <= 1'b1;
        end
        StLoad: begin
          half_q <= ~half_q;
          if (half_q) rnd_q <= Rw'(1);
        end
        StRound: begin
          half_q <= ~half_q;
          if (half_q) rnd_q <= rnd_q + Rw'(1);
          if (half_q && rnd_q == Rw'(Rounds)) res_q <= rnd_out;
        end
        StOut: ;
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dec_q <= action_i;
      blk_q <= {block_high_i, block_low_i};
      w_q[0] <= key_hi_q[63:32]; w_q[1] <= key_hi_q[31:0];
      w_q[2] <= key_lo_q[63:32]; w_q[3] <= key_lo_q[31:0];
      rc_q   <= 8'h01;
    end
    if (state_q == StExp) begin
      hold_q <= cur_w;
      if (ecnt_q >= Ew'(4)) begin
        w_q[0] <= w_q[1]; w_q[1] <= w_q[2]; w_q[2] <= w_q[3]; w_q[3] <= new_w;
        if (ecnt_q[1:0] == 2'd0) rc_q <= xtime(rc_q);
      end
    end
    if (!half_q) rk_hi_q <= ram_rd;
    if (state_q == StLoad && half_q) blk_q <= blk_q ^ {rk_hi_q, ram_rd};
    if (state_q == StRound && half_q) blk_q <= rnd_out;
  end

  `AES_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_q))
  `AES_ASSERT_IMP(a_busy_stall, state_q != StIdle, in_stall_o)
  `AES_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(res_q))
  `AES_ASSERT_NXT(a_exp_done, state_q == StExp && state_d == StLoad, keys_ok_q)
endmodule
